// ===== rtl/core/plst_pkg.sv =====
// shared constants, codes and types for the positional list store
package plst_pkg;

  localparam int CAPACITY    = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int FUNC_W      = 3;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 6;
  localparam int ST_W        = 2;
  localparam int ENT_W       = 6;
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + ENT_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_POS   = 3'd1,
    FN_INS_BACK  = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_POS   = 3'd4,
    FN_DEL_BACK  = 3'd5,
    FN_READ_ALL  = 3'd6
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic                  rot;
    logic [IDX_W-1:0]      q;
    logic [DATA_WIDTH-1:0] val;
  } cell_ctrl_t;

  function automatic logic [VAL_W-1:0] ext_value(input logic [DATA_WIDTH-1:0] d);
    ext_value = VAL_W'($signed(d));
  endfunction

endpackage

// ===== rtl/core/positional_list_store.sv =====
// top level of the positional list store: control, result register and the ring of cells
// inserts, deletes and errors: the result is written straight into the output register on acceptance
// a read of n entries gives n words and steps the ring until it has made CAPACITY steps in all
// (one step of the cell ring per cycle, held while a word waits on a stalled output)
// and is home; a new word is taken once the ring is home and the output register is free
// rst_n (synchronous, active low) empties the list; cell data is not cleared
module positional_list_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [plst_pkg::IN_TDATA_W-1:0]  in_tdata,  // value[31:0], position[37:32], zero pad
  input  logic [plst_pkg::FUNC_W-1:0]      in_tuser,  // func[2:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [plst_pkg::OUT_TDATA_W-1:0] out_tdata, // entry_value[31:0], entries_now[37:32]
  output logic [plst_pkg::ST_W-1:0]        out_tuser, // status[1:0]
  output logic                             out_tlast
);
  import plst_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_st_r;
  logic [VAL_W-1:0]      out_val_r;
  logic [ENT_W-1:0]      out_ent_r;
  logic                  out_last_r;

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  cell_ctrl_t            ctrl;

  func_t                 func;
  logic [VAL_W-1:0]      in_value;
  logic [POS_W-1:0]      in_pos;
  logic [CMP_W-1:0]      pos_c, cnt_c;
  status_t               res_st;
  logic [VAL_W-1:0]      res_val;
  logic                  op_ins, op_del, go_read;
  logic [IDX_W-1:0]      op_q;
  logic [CNT_W-1:0]      op_cnt;

  logic                  in_fire, out_free, has_entry, emit, rotate, rd_done;

  assign in_value = in_tdata[VAL_W-1:0];
  assign in_pos   = in_tdata[VAL_W+POS_W-1:VAL_W];
  assign func     = func_t'(in_tuser);
  assign pos_c    = CMP_W'(in_pos);
  assign cnt_c    = CMP_W'(cnt_r);
  assign out_free = !out_valid_r || out_tready;
  assign in_fire  = in_tvalid && in_tready;

  // decode of one accepted word
  always_comb begin
    res_st  = ST_OK;
    res_val = '0;
    op_ins  = 1'b0;
    op_del  = 1'b0;
    op_q    = '0;
    op_cnt  = cnt_r;
    go_read = 1'b0;
    case (func)
      FN_INS_FRONT, FN_INS_POS, FN_INS_BACK: begin
        if (cnt_r == CNT_W'(CAPACITY)) begin
          res_st = ST_FULL;
        end else if (func == FN_INS_POS && cnt_r != '0 &&
                     (pos_c == '0 || pos_c > cnt_c + CMP_W'(1))) begin
          res_st = ST_BAD_POS;
        end else begin
          op_ins = 1'b1;
          op_cnt = cnt_r + CNT_W'(1);
          if (func == FN_INS_BACK) begin
            op_q = IDX_W'(cnt_r);
          end else if (func == FN_INS_POS && cnt_r != '0) begin
            op_q = IDX_W'(pos_c - CMP_W'(1));
          end
        end
      end
      FN_DEL_FRONT, FN_DEL_POS, FN_DEL_BACK: begin
        if (cnt_r == '0) begin
          res_st = ST_EMPTY;
        end else if (func == FN_DEL_POS && (pos_c == '0 || pos_c > cnt_c)) begin
          res_st = ST_BAD_POS;
        end else begin
          op_del = 1'b1;
          op_cnt = cnt_r - CNT_W'(1);
          if (func == FN_DEL_BACK) begin
            op_q = IDX_W'(cnt_r - CNT_W'(1));
          end else if (func == FN_DEL_POS) begin
            op_q = IDX_W'(pos_c - CMP_W'(1));
          end
          res_val = ext_value(cell_q[op_q]);
        end
      end
      FN_READ_ALL: begin
        if (cnt_r == '0) begin
          res_st = ST_EMPTY;
        end else begin
          go_read = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && go_read) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (rd_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    emit      = 1'b0;
    rotate    = 1'b0;
    rd_done   = 1'b0;
    has_entry = CNT_W'(rd_cnt_r) < cnt_r;
    case (state_r)
      S_IDLE: begin
        in_tready = out_free;
      end
      S_READ: begin
        emit    = has_entry && out_free;
        rotate  = !has_entry || out_free;
        rd_done = rotate && rd_cnt_r == IDX_W'(CAPACITY - 1);
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (in_fire) begin
      rd_cnt_nxt = '0;
    end else if (rotate) begin
      rd_cnt_nxt = rd_cnt_r + IDX_W'(1);
    end
  end

  assign cnt_nxt       = in_fire ? op_cnt : cnt_r;
  assign out_valid_nxt = (out_valid_r && !out_tready) || (in_fire && !go_read) || emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !go_read) begin
      out_st_r   <= res_st;
      out_val_r  <= res_val;
      out_ent_r  <= ENT_W'(op_cnt);
      out_last_r <= 1'b1;
    end else if (emit) begin
      out_st_r   <= ST_OK;
      out_val_r  <= ext_value(cell_q[0]);
      out_ent_r  <= ENT_W'(cnt_r);
      out_last_r <= CNT_W'(rd_cnt_r) == cnt_r - CNT_W'(1);
    end
  end

  assign ctrl.ins = in_fire && op_ins;
  assign ctrl.del = in_fire && op_del;
  assign ctrl.rot = rotate;
  assign ctrl.q   = op_q;
  assign ctrl.val = DATA_WIDTH'($signed(in_value));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plst_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctrl     (ctrl),
      .left_d   (cell_q[(i + CAPACITY - 1) % CAPACITY]),
      .right_d  (cell_q[(i + 1) % CAPACITY]),
      .data_q   (cell_q[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_ent_r, out_val_r});
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && func == FN_READ_ALL && cnt_r != '0) |=> state_r == S_READ)
    else $error("read of a non-empty list did not start");

  a_read_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> $stable(cnt_r))
    else $error("entry count changed during a read");

  a_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> state_r == S_READ)
    else $error("non-final word outside a read");

endmodule

// ===== rtl/core/plst_cell.sv =====
// one list cell: holds the entry at its position and trades words with its neighbours
module plst_cell (
  input  logic                            clk,
  input  logic [plst_pkg::IDX_W-1:0]      cell_idx,
  input  plst_pkg::cell_ctrl_t            ctrl,
  input  logic [plst_pkg::DATA_WIDTH-1:0] left_d,
  input  logic [plst_pkg::DATA_WIDTH-1:0] right_d,
  output logic [plst_pkg::DATA_WIDTH-1:0] data_q
);
  import plst_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.rot) begin
      data_nxt = right_d;
    end else if (ctrl.ins) begin
      if (cell_idx > ctrl.q) begin
        data_nxt = left_d;
      end else if (cell_idx == ctrl.q) begin
        data_nxt = ctrl.val;
      end
    end else if (ctrl.del) begin
      if (cell_idx >= ctrl.q) begin
        data_nxt = right_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
